// ----- hdl/rdq_pkg.sv -----
// Package for the record deque: sizes, record type, action codes and cell commands.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rdq_pkg;

	// Storage size and record payload width
	localparam int DEPTH        = 16;
	localparam int PAYLOAD_BITS = 32;

	// Fixed port field widths
	localparam int ACT_W     = 3;
	localparam int KEY_W     = 31;
	localparam int PAY_IN_W  = 32;
	localparam int POS_W     = 5;
	localparam int OUT_CNT_W = 5;

	// Derived widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Request codes
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_FETCH      = 3'd4,
		ACT_FIND       = 3'd5,
		ACT_SIZE       = 3'd6
	} act_t;

	// One stored record
	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic [PAYLOAD_BITS-1:0] payload;
	} rec_t;

	// Command broadcast to every cell of the ring
	typedef enum logic [1:0] {
		CELL_HOLD     = 2'd0,
		CELL_SHIFT_IN = 2'd1,
		CELL_ROTATE   = 2'd2,
		CELL_APPEND   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] count;
		rec_t             rec_in;
	} cell_ctl_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_WALK = 2'd1,
		ST_HOLD = 2'd2
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/rdq_ifs.sv -----
// Request and response channel interfaces of the record deque.
// Depends on rdq_pkg for field widths.
`default_nettype none

interface rdq_req_if import rdq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [KEY_W-1:0]    entry_key;
	logic [PAY_IN_W-1:0] entry_payload;
	logic [POS_W-1:0]    position;

	modport source (output valid, action, entry_key, entry_payload, position, input ready);
	modport sink (input valid, action, entry_key, entry_payload, position, output ready);
endinterface

interface rdq_rsp_if import rdq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [KEY_W-1:0]     found_key;
	logic [PAY_IN_W-1:0]  found_payload;
	logic [OUT_CNT_W-1:0] entry_count;

	modport source (output valid, ok, found_key, found_payload, entry_count, input ready);
	modport sink (input valid, ok, found_key, found_payload, entry_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/rdq_cell.sv -----
// One storage cell of the record ring: holds a record and takes its neighbour's.
// Depends on rdq_pkg.
`default_nettype none

module rdq_cell import rdq_pkg::*; (
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [IDX_W-1:0] slot,
	input  wire rec_t             prev_rec,
	input  wire rec_t             next_rec,
	output rec_t                  rec
);

	rec_t rec_q;

	// Shift towards the back, rotate towards the front, or take an appended record
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_SHIFT_IN: rec_q <= prev_rec;
			CELL_ROTATE:   rec_q <= next_rec;
			CELL_APPEND: begin
				if (CNT_W'(slot) == ctl.count) begin
					rec_q <= ctl.rec_in;
				end
			end
			default: rec_q <= rec_q;
		endcase
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

// ----- hdl/record_deque_with_search.sv -----
// Record deque with search: a ring of DEPTH cells kept in list order, cell 0 the front.
// Push, pop, size: the result is registered, or parked in ST_HOLD while the response
// register is busy; one item per cycle while it is free. Fetch, find: the ring rotates
// once per cycle for a full turn as cell 0 is examined; no new item until the result is out.
// Reset clears the count, the sequencer and the response valid; cells are not cleared.
// Depends on rdq_pkg, rdq_ifs and rdq_cell.
`default_nettype none

module record_deque_with_search import rdq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rdq_req_if.sink   req,
	rdq_rsp_if.source rsp
);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, cnt_d;
	logic [IDX_W-1:0]    step_q;
	logic                wk_find_q;
	logic [KEY_W-1:0]    wk_key_q;
	logic [POS_W-1:0]    wk_pos_q;
	logic                res_ok_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [PAY_IN_W-1:0] out_pay_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;

	cell_ctl_t ctl;
	cell_op_t  ctl_op;
	rec_t      rec_w [DEPTH];
	rec_t      new_rec;

	logic accept, walk_start, cap, hit_now, last_step, out_free;
	logic fin_valid, fin_ok;
	logic [KEY_W-1:0]        fin_key;
	logic [PAYLOAD_BITS-1:0] fin_pay;
	logic [CNT_W-1:0]        fin_cnt;
	logic full, empty;

	assign new_rec.key     = req.entry_key;
	assign new_rec.payload = PAYLOAD_BITS'(req.entry_payload);

	assign ctl.op     = ctl_op;
	assign ctl.count  = count_q;
	assign ctl.rec_in = new_rec;

	// Ring of cells: cell 0 shifts in the new record; on rotate cell 0 wraps to the last cell
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		rdq_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.slot     (IDX_W'(g)),
			.prev_rec ((g == 0) ? new_rec : rec_w[(g + DEPTH - 1) % DEPTH]),
			.next_rec (rec_w[(g + 1) % DEPTH]),
			.rec      (rec_w[g])
		);
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign last_step = (step_q == IDX_W'(DEPTH - 1));

	// Match at the current walk step: record at offset step_q sits in cell 0
	assign hit_now = (CNT_W'(step_q) < count_q) && !res_ok_q &&
		(wk_find_q ? (rec_w[0].key == wk_key_q)
		           : (CMP_W'(step_q) + CMP_W'(1) == CMP_W'(wk_pos_q)));

	// Decode requests, drive the ring and form results
	always_comb begin
		state_d    = state_q;
		cnt_d      = count_q;
		ctl_op     = CELL_HOLD;
		walk_start = 1'b0;
		cap        = 1'b0;
		fin_valid  = 1'b0;
		fin_ok     = 1'b0;
		fin_key    = '0;
		fin_pay    = '0;
		fin_cnt    = count_q;
		req.ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					fin_valid = 1'b1;
					case (act_t'(req.action))
						ACT_PUSH_FRONT: begin
							if (!full) begin
								ctl_op = CELL_SHIFT_IN;
								cnt_d  = count_q + CNT_W'(1);
								fin_ok = 1'b1;
							end
						end
						ACT_PUSH_BACK: begin
							if (!full) begin
								ctl_op = CELL_APPEND;
								cnt_d  = count_q + CNT_W'(1);
								fin_ok = 1'b1;
							end
						end
						ACT_POP_FRONT: begin
							if (!empty) begin
								ctl_op = CELL_ROTATE;
								cnt_d  = count_q - CNT_W'(1);
								fin_ok = 1'b1;
							end
						end
						ACT_POP_BACK: begin
							if (!empty) begin
								cnt_d  = count_q - CNT_W'(1);
								fin_ok = 1'b1;
							end
						end
						ACT_FETCH, ACT_FIND: begin
							fin_valid  = 1'b0;
							walk_start = 1'b1;
							state_d    = ST_WALK;
						end
						ACT_SIZE: fin_ok = 1'b1;
						default:  fin_ok = 1'b0;
					endcase
					fin_cnt = cnt_d;
				end
			end
			ST_WALK: begin
				ctl_op = CELL_ROTATE;
				// The last step hands its match straight to the result
				cap    = hit_now && !last_step;
				if (last_step) begin
					fin_valid = 1'b1;
					fin_ok    = res_ok_q || hit_now;
					fin_key   = hit_now ? rec_w[0].key : res_key_q;
					fin_pay   = hit_now ? rec_w[0].payload : res_pay_q;
				end
			end
			ST_HOLD: begin
				fin_valid = 1'b1;
				fin_ok    = res_ok_q;
				fin_key   = res_key_q;
				fin_pay   = res_pay_q;
				fin_cnt   = res_cnt_q;
			end
			default: state_d = ST_IDLE;
		endcase
		// Deliver now, or park the result until the response register frees
		if (fin_valid) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_d;
			if (state_q == ST_WALK) begin
				step_q <= last_step ? '0 : step_q + IDX_W'(1);
			end
			if (fin_valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture walk parameters, partial results and the response payload
	always_ff @(posedge clk) begin
		if (walk_start) begin
			wk_find_q <= (act_t'(req.action) == ACT_FIND);
			wk_key_q  <= req.entry_key;
			wk_pos_q  <= req.position;
			res_ok_q  <= 1'b0;
			res_key_q <= '0;
			res_pay_q <= '0;
		end
		if (cap) begin
			res_ok_q  <= 1'b1;
			res_key_q <= rec_w[0].key;
			res_pay_q <= rec_w[0].payload;
		end
		if (fin_valid && !out_free) begin
			res_ok_q  <= fin_ok;
			res_key_q <= fin_key;
			res_pay_q <= fin_pay;
			res_cnt_q <= fin_cnt;
		end
		if (fin_valid && out_free) begin
			out_ok_q  <= fin_ok;
			out_key_q <= fin_key;
			out_pay_q <= PAY_IN_W'(fin_pay);
			out_cnt_q <= OUT_CNT_W'(fin_cnt);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.found_key     = out_key_q;
	assign rsp.found_payload = out_pay_q;
	assign rsp.entry_count   = out_cnt_q;

	// Count never exceeds the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("record count beyond depth");

	// A fetch or find item starts a walk
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.action == ACT_FETCH || req.action == ACT_FIND)) |=> state_q == ST_WALK)
		else $error("walk not started");

	// The count holds while the ring rotates
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |=> $stable(count_q))
		else $error("count changed during walk");

	// The step counter rests at zero outside a walk
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WALK) |-> step_q == '0)
		else $error("walk step not at rest");

endmodule

`default_nettype wire
